/* hw/rtl/yuv420_block_to_rgb_core_macros.svh */
// Assertion macros used by the checker file of the YUV 4:2:0 to RGB core.
`ifndef YUV420_BLOCK_TO_RGB_CORE_MACROS_SVH
`define YUV420_BLOCK_TO_RGB_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define YUV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define YUV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/yuv2rgb_pkg.sv */
// Types, constants and arithmetic helpers of the YUV 4:2:0 block to RGB888 core.
package yuv2rgb_pkg;

    localparam int PIX_W   = 8;
    localparam int IN_W    = 6 * PIX_W;
    localparam int OUT_W   = 12 * PIX_W;
    localparam int PROD_W  = 18;
    localparam int OFS_W   = 10;
    localparam int SUM_W   = 10;
    localparam int SCALE_SH = 8;

    localparam logic signed [PROD_W-1:0] COEF_R_V   = 18'sd351;
    localparam logic signed [PROD_W-1:0] COEF_G_V   = 18'sd179;
    localparam logic signed [PROD_W-1:0] COEF_G_U   = 18'sd86;
    localparam logic signed [PROD_W-1:0] COEF_B_U   = 18'sd444;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = 18'sd255;
    localparam logic signed [SUM_W-1:0]  CHAN_MAX   = 10'sd255;

    typedef struct packed {
        logic [PIX_W-1:0] luma_bottom_right;
        logic [PIX_W-1:0] luma_bottom_left;
        logic [PIX_W-1:0] luma_top_right;
        logic [PIX_W-1:0] luma_top_left;
        logic [PIX_W-1:0] chroma_v;
        logic [PIX_W-1:0] chroma_u;
    } yuv_block_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue_bottom_right;
        logic [PIX_W-1:0] green_bottom_right;
        logic [PIX_W-1:0] red_bottom_right;
        logic [PIX_W-1:0] blue_bottom_left;
        logic [PIX_W-1:0] green_bottom_left;
        logic [PIX_W-1:0] red_bottom_left;
        logic [PIX_W-1:0] blue_top_right;
        logic [PIX_W-1:0] green_top_right;
        logic [PIX_W-1:0] red_top_right;
        logic [PIX_W-1:0] blue_top_left;
        logic [PIX_W-1:0] green_top_left;
        logic [PIX_W-1:0] red_top_left;
    } rgb_block_t;

    // Remove the chroma bias: flipping the top bit gives sample - 128.
    function automatic logic signed [PIX_W-1:0] unbias(input logic [PIX_W-1:0] c);
        return $signed({~c[PIX_W-1], c[PIX_W-2:0]});
    endfunction

    // Divide by 256 with truncation toward zero.
    function automatic logic signed [OFS_W-1:0] div_scale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p + (p[PROD_W-1] ? TRUNC_BIAS : '0);
        return OFS_W'(adj >>> SCALE_SH);
    endfunction

    // Add offset to luma and saturate to 0..255.
    function automatic logic [PIX_W-1:0] chan(input logic [PIX_W-1:0] y,
                                              input logic signed [OFS_W-1:0] d);
        logic signed [SUM_W-1:0] s;
        s = $signed({2'b00, y}) + d;
        if (s[SUM_W-1])
        begin
            return '0;
        end
        else if (s > CHAN_MAX)
        begin
            return '1;
        end
        return s[PIX_W-1:0];
    endfunction

endpackage

/* hw/rtl/yuv420_block_to_rgb_core.sv */
// Converts one 2x2 block of a 4:2:0 image (U, V, four luma) to four RGB888 pixels.
// One block enters per clock while s_tready is high: an input register feeds the
// chroma products, the truncating divide by 256, the luma add and the saturation,
// and a result register holds the four pixels. While a result waits, the
// input register still takes one more block; the input is held off only while both
// registers hold a word and m_tready is low, and s_tready follows m_tready in the same
// cycle, so no bubble follows a stall. The chroma offsets follow BT.601 integer
// weights 351, 179, 86 and 444 over 256, truncated toward zero; every channel
// saturates to 0..255.
module yuv420_block_to_rgb_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // chroma_u, chroma_v, luma_top_left, luma_top_right, luma_bottom_left,
    // luma_bottom_right
    input  logic [yuv2rgb_pkg::IN_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // red/green/blue top_left, red/green/blue top_right, red/green/blue bottom_left,
    // red/green/blue bottom_right
    output logic [yuv2rgb_pkg::OUT_W-1:0]  m_tdata
);
    import yuv2rgb_pkg::*;

    yuv_block_t              in_reg;
    logic                    in_valid_reg;
    rgb_block_t              out_reg;
    logic                    out_valid_reg;
    rgb_block_t              rgb_next;
    logic                    out_ready;
    logic signed [PIX_W-1:0] cu;
    logic signed [PIX_W-1:0] cv;
    logic signed [OFS_W-1:0] dr;
    logic signed [OFS_W-1:0] dg;
    logic signed [OFS_W-1:0] db;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_comb
    begin
        cu = unbias(in_reg.chroma_u);
        cv = unbias(in_reg.chroma_v);
        dr = div_scale(PROD_W'(cv) * COEF_R_V);
        dg = -div_scale(PROD_W'(cv) * COEF_G_V) - div_scale(PROD_W'(cu) * COEF_G_U);
        db = div_scale(PROD_W'(cu) * COEF_B_U);

        rgb_next.red_top_left       = chan(in_reg.luma_top_left, dr);
        rgb_next.green_top_left     = chan(in_reg.luma_top_left, dg);
        rgb_next.blue_top_left      = chan(in_reg.luma_top_left, db);
        rgb_next.red_top_right      = chan(in_reg.luma_top_right, dr);
        rgb_next.green_top_right    = chan(in_reg.luma_top_right, dg);
        rgb_next.blue_top_right     = chan(in_reg.luma_top_right, db);
        rgb_next.red_bottom_left    = chan(in_reg.luma_bottom_left, dr);
        rgb_next.green_bottom_left  = chan(in_reg.luma_bottom_left, dg);
        rgb_next.blue_bottom_left   = chan(in_reg.luma_bottom_left, db);
        rgb_next.red_bottom_right   = chan(in_reg.luma_bottom_right, dr);
        rgb_next.green_bottom_right = chan(in_reg.luma_bottom_right, dg);
        rgb_next.blue_bottom_right  = chan(in_reg.luma_bottom_right, db);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= yuv_block_t'(s_tdata);
        end
        if (in_valid_reg && out_ready)
        begin
            out_reg <= rgb_next;
        end
    end

endmodule

/* hw/rtl/yuv2rgb_chk.sv */
// Port checker of the YUV 4:2:0 to RGB core and its bind.
`include "yuv420_block_to_rgb_core_macros.svh"

module yuv2rgb_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [yuv2rgb_pkg::OUT_W-1:0] m_tdata
);

    `YUV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped or changed while stalled")
    `YUV_ASSERT_NOW(a_in_stall, !s_tready, m_tvalid && !m_tready, "input stalled without a full pipe")
    `YUV_ASSERT_NOW(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "output word without an input word two cycles earlier")

endmodule

bind yuv420_block_to_rgb_core yuv2rgb_chk u_yuv2rgb_chk (.*);
